FILE: rtl/fue_pkg.sv
// ----------------------------------------------------------------------------
// fue_pkg
// Shared types and constants for the frame unescape and XOR check block.
// ----------------------------------------------------------------------------
package fue_pkg;

  // Framing bytes
  localparam logic [7:0] FLAG_BYTE     = 8'h7e;
  localparam logic [7:0] ESC_BYTE      = 8'h7d;
  localparam logic [7:0] ESC_CODE_ESC  = 8'h01;
  localparam logic [7:0] ESC_CODE_FLAG = 8'h02;

  // Message ids that are classified
  localparam logic [15:0] ID_HEARTBEAT = 16'h0002;
  localparam logic [15:0] ID_ALARM     = 16'h01f0;
  localparam logic [15:0] ID_PARAMETER = 16'h01f1;

  // Sizes
  localparam int MAX_FRAME_DEF = 1024;
  localparam int LEN_W         = 11;
  localparam int MIN_FRAME     = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FLAGS  = 2'd1,
    ST_BAD_SUM   = 2'd2,
    ST_TOO_SHORT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CL_HEARTBEAT = 2'd0,
    CL_ALARM     = 2'd1,
    CL_PARAMETER = 2'd2,
    CL_OTHER     = 2'd3
  } class_t;

  // One decoded byte with its (possibly zero) verdict
  typedef struct packed {
    logic [7:0]       decoded_byte;
    logic             is_last;
    status_t          status;
    logic [15:0]      msg_id;
    class_t           msg_class;
    logic             ack_needed;
    logic [LEN_W-1:0] frame_length;
  } result_t;

  // Up to two results produced by one input transaction
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic class_t classify(input logic [15:0] id);
    class_t c;
    if (id == ID_HEARTBEAT) c = CL_HEARTBEAT;
    else if (id == ID_ALARM) c = CL_ALARM;
    else if (id == ID_PARAMETER) c = CL_PARAMETER;
    else c = CL_OTHER;
    return c;
  endfunction

endpackage

FILE: rtl/fue_decode.sv
// ----------------------------------------------------------------------------
// fue_decode
// Unescape one raw byte per transaction, keep the frame state and build up
// to two results (a held-back literal 7d plus the current byte).
// ----------------------------------------------------------------------------
module fue_decode import fue_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output push_t      push
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  typedef struct packed {
    logic             escape_pending;
    logic [7:0]       running_xor;
    logic [7:0]       first_decoded;
    logic [7:0]       previous_decoded;
    logic [7:0]       latest_decoded;
    logic [15:0]      id_register;
    logic [CNT_W-1:0] decoded_count;
  } frame_t;

  typedef struct packed {
    frame_t  st;
    result_t res;
  } emit_t;

  // One decoded byte: update the frame state, give the verdict on the last
  function automatic emit_t emit(input frame_t s, input logic [7:0] b, input logic last);
    emit_t      e;
    frame_t     n;
    logic [7:0] sum;
    status_t    st;
    class_t     cl;
    n = s;
    n.escape_pending = 1'b0;
    if (s.decoded_count == '0) n.first_decoded = b;
    if (s.decoded_count == CNT_W'(1)) n.id_register = {b, 8'h00};
    if (s.decoded_count == CNT_W'(2)) n.id_register = s.id_register | {8'h00, b};
    if (s.decoded_count != '0) n.running_xor = s.running_xor ^ b;
    n.previous_decoded = s.latest_decoded;
    n.latest_decoded   = b;
    if (s.decoded_count < CNT_W'(MAX_FRAME)) n.decoded_count = s.decoded_count + CNT_W'(1);

    sum = n.running_xor ^ n.previous_decoded ^ n.latest_decoded;
    if (n.decoded_count < CNT_W'(MIN_FRAME)) st = ST_TOO_SHORT;
    else if (n.first_decoded != FLAG_BYTE || n.latest_decoded != FLAG_BYTE) st = ST_NO_FLAGS;
    else if (sum != n.previous_decoded) st = ST_BAD_SUM;
    else st = ST_OK;
    cl = classify(n.id_register);

    e.res = '0;
    e.res.decoded_byte = b;
    e.st = n;
    if (last) begin
      e.res.is_last      = 1'b1;
      e.res.status       = st;
      e.res.msg_id       = n.id_register;
      e.res.msg_class    = cl;
      e.res.ack_needed   = (st == ST_OK) && (cl != CL_OTHER);
      e.res.frame_length = LEN_W'(n.decoded_count);
      e.st = '0;
    end
    return e;
  endfunction

  frame_t     frame;
  frame_t     frame_next;
  emit_t      e0;
  emit_t      e1;
  logic [7:0] b0;
  logic       l0;
  logic       mapped;
  logic       hold;

  // Escape decode
  always_comb begin
    mapped = (data_byte == ESC_CODE_ESC) || (data_byte == ESC_CODE_FLAG);
    hold   = (data_byte == ESC_BYTE) && !end_of_buffer;
    if (frame.escape_pending) begin
      b0 = (data_byte == ESC_CODE_FLAG) ? FLAG_BYTE : ESC_BYTE;
      l0 = end_of_buffer && mapped;
    end else begin
      b0 = data_byte;
      l0 = end_of_buffer;
    end
    e0 = emit(frame, b0, l0);
    e1 = emit(e0.st, data_byte, end_of_buffer);
  end

  // Result count and next frame state
  always_comb begin
    push.r0 = e0.res;
    push.r1 = e1.res;
    if (frame.escape_pending) begin
      if (mapped) begin
        push.cnt   = 2'd1;
        frame_next = e0.st;
      end else if (hold) begin
        push.cnt   = 2'd1;
        frame_next = e0.st;
        frame_next.escape_pending = 1'b1;
      end else begin
        push.cnt   = 2'd2;
        frame_next = e1.st;
      end
    end else if (hold) begin
      push.cnt   = 2'd0;
      frame_next = frame;
      frame_next.escape_pending = 1'b1;
    end else begin
      push.cnt   = 2'd1;
      frame_next = e0.st;
    end
    if (!accept) push.cnt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (accept) begin
      frame <= frame_next;
    end
  end

endmodule

FILE: rtl/fue_out_queue.sv
// ----------------------------------------------------------------------------
// fue_out_queue
// Small result queue: takes up to two results a cycle, gives one while ready.
// ----------------------------------------------------------------------------
module fue_out_queue import fue_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  result_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign out_res   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.cnt == 2'd2) mem[wr_ptr + QPTR_W'(1)] <= push.r1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.cnt);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push.cnt) - QCNT_W'(pop);
    end
  end

endmodule

FILE: rtl/frame_unescape_xor_check.sv
// Results are written into the result queue and offered from its head.
// Throughput: one raw byte per cycle while the queue has room; a byte
// that yields two results (a literal 7d plus itself) sends both through
// the one-result-per-cycle output port, absorbed by a four-entry queue.
// Reset: synchronous, clears frame state and the result queue.
// ----------------------------------------------------------------------------
// frame_unescape_xor_check
// Unescapes a received buffer byte by byte, checks flags, length and XOR sum, and classifies the message id.
// ----------------------------------------------------------------------------
module frame_unescape_xor_check import fue_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             data_valid,
  output logic             data_ready,
  input  logic [7:0]       data_byte,
  input  logic             end_of_buffer,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [7:0]       decoded_byte,
  output logic             is_last,
  output logic [1:0]       status,
  output logic [15:0]      msg_id,
  output logic [1:0]       msg_class,
  output logic             ack_needed,
  output logic [LEN_W-1:0] frame_length
);

  push_t   push;
  result_t res;
  logic    accept;

  assign accept = data_valid && data_ready;

  fue_decode #(
    .MAX_FRAME(MAX_FRAME)
  ) u_decode (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .push          (push)
  );

  fue_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (data_ready),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_res   (res)
  );

  // Result fields
  assign decoded_byte = res.decoded_byte;
  assign is_last      = res.is_last;
  assign status       = res.status;
  assign msg_id       = res.msg_id;
  assign msg_class    = res.msg_class;
  assign ack_needed   = res.ack_needed;
  assign frame_length = res.frame_length;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame unescape and XOR check block. Escaped
// raw buffers go in over a valid/ready channel. A built-in model decodes
// them, tracks the frame state and predicts every decoded byte and verdict.
// Each result is compared field by field. Both channels idle at random, the
// receiver holds off long enough to back the block up, and the sender
// pauses until the block has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import fue_pkg::*;

  localparam int MAX_LEN        = MAX_FRAME_DEF;
  localparam int ITEM_TARGET    = 1850;
  localparam int DRAIN_SPACING  = 350;
  localparam int LONG_HOLD      = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 10;

  typedef struct {
    logic [7:0] data;
    logic       eob;
    logic       drain;   // not a byte: wait until every result is back
  } raw_item_t;

  // DUT connections
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             data_valid = 1'b0;
  logic             data_ready;
  logic [7:0]       data_byte = '0;
  logic             end_of_buffer = 1'b0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  logic [7:0]       decoded_byte;
  logic             is_last;
  logic [1:0]       status;
  logic [15:0]      msg_id;
  logic [1:0]       msg_class;
  logic             ack_needed;
  logic [LEN_W-1:0] frame_length;

  // Stimulus and expectations
  raw_item_t  raw_stream[$];
  logic [7:0] frame_buf[$];
  result_t    expected_decoded[$];

  // Frame state of the decoder model
  logic             esc_pending = 1'b0;
  logic [7:0]       xor_acc     = '0;
  logic [7:0]       first_byte  = '0;
  logic [7:0]       prev_byte   = '0;
  logic [7:0]       newest_byte = '0;
  logic [15:0]      id_reg      = '0;
  logic [LEN_W-1:0] byte_count  = '0;

  // Bookkeeping
  int fail_count      = 0;
  int bytes_sent      = 0;
  int results_checked = 0;
  int longest_frame   = 0;
  int verdict_tally[4];
  int idle_cycles     = 0;
  int send_gap        = 0;
  int send_burst      = 0;
  int recv_stall      = 0;
  int recv_burst      = 0;
  raw_item_t next_raw;

  frame_unescape_xor_check #(.MAX_FRAME(MAX_LEN)) uut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .end_of_buffer(end_of_buffer),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .decoded_byte (decoded_byte),
    .is_last      (is_last),
    .status       (status),
    .msg_id       (msg_id),
    .msg_class    (msg_class),
    .ack_needed   (ack_needed),
    .frame_length (frame_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  // Account one decoded byte; on the last byte form the verdict and clear
  function automatic void emit_decoded(input logic [7:0] b, input logic last);
    result_t    r;
    logic [7:0] sum;
    status_t    st;
    class_t     cl;
    if (byte_count == 0) first_byte = b;
    if (byte_count == 1) id_reg = {b, 8'h00};
    if (byte_count == 2) id_reg[7:0] = b;
    if (byte_count >= 1) xor_acc ^= b;
    prev_byte   = newest_byte;
    newest_byte = b;
    if (byte_count < MAX_LEN) byte_count++;
    r = '0;
    r.decoded_byte = b;
    if (last) begin
      // checksum byte sits in the sum too, so take it and the flag back out
      sum = xor_acc ^ prev_byte ^ newest_byte;
      if (byte_count < MIN_FRAME) st = ST_TOO_SHORT;
      else if (first_byte != FLAG_BYTE || newest_byte != FLAG_BYTE) st = ST_NO_FLAGS;
      else if (sum != prev_byte) st = ST_BAD_SUM;
      else st = ST_OK;
      case (id_reg)
        ID_HEARTBEAT: cl = CL_HEARTBEAT;
        ID_ALARM:     cl = CL_ALARM;
        ID_PARAMETER: cl = CL_PARAMETER;
        default:      cl = CL_OTHER;
      endcase
      r.is_last      = 1'b1;
      r.status       = st;
      r.msg_id       = id_reg;
      r.msg_class    = cl;
      r.ack_needed   = (st == ST_OK) && (cl != CL_OTHER);
      r.frame_length = byte_count;
      esc_pending = 1'b0;
      xor_acc     = '0;
      first_byte  = '0;
      prev_byte   = '0;
      newest_byte = '0;
      id_reg      = '0;
      byte_count  = '0;
    end
    expected_decoded.push_back(r);
  endfunction

  // One raw byte: zero, one or two decoded bytes
  function automatic void unescape_byte(input logic [7:0] d, input logic eob);
    if (esc_pending) begin
      esc_pending = 1'b0;
      if (d == ESC_CODE_ESC || d == ESC_CODE_FLAG) begin
        emit_decoded(d == ESC_CODE_ESC ? ESC_BYTE : FLAG_BYTE, eob);
        return;
      end
      // not an escape code: the held 7d goes out literally
      emit_decoded(ESC_BYTE, 1'b0);
    end
    if (d == ESC_BYTE && !eob) esc_pending = 1'b1;
    else emit_decoded(d, eob);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic put_raw(input logic [7:0] b, input logic eob);
    raw_item_t it;
    it.data  = b;
    it.eob   = eob;
    it.drain = 1'b0;
    raw_stream.push_back(it);
  endtask

  task automatic put_drain();
    raw_item_t it;
    it.data  = '0;
    it.eob   = 1'b0;
    it.drain = 1'b1;
    raw_stream.push_back(it);
  endtask

  // Byte source weighted toward the framing and escape codes
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = FLAG_BYTE;
      1:       b = ESC_BYTE;
      2:       b = ESC_CODE_ESC;
      3:       b = ESC_CODE_FLAG;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Decoded frame with flags, id, body and checksum into frame_buf
  task automatic build_frame(input logic [15:0] id, input int n_body,
                             input logic sum_ok);
    logic [7:0] cs;
    logic [7:0] b;
    frame_buf.delete();
    frame_buf.push_back(FLAG_BYTE);
    frame_buf.push_back(id[15:8]);
    frame_buf.push_back(id[7:0]);
    cs = id[15:8] ^ id[7:0];
    for (int i = 0; i < n_body; i++) begin
      b = pick_byte();
      frame_buf.push_back(b);
      cs ^= b;
    end
    if (!sum_ok) cs ^= 8'($urandom_range(1, 255));
    frame_buf.push_back(cs);
    frame_buf.push_back(FLAG_BYTE);
  endtask

  // Escape the interior of frame_buf and queue it as one buffer
  task automatic put_frame();
    int         n;
    logic [7:0] b;
    logic       last;
    n = frame_buf.size();
    for (int i = 0; i < n; i++) begin
      b    = frame_buf[i];
      last = (i == n - 1);
      if (i > 0 && !last && (b == FLAG_BYTE || b == ESC_BYTE)) begin
        put_raw(ESC_BYTE, 1'b0);
        put_raw(b == ESC_BYTE ? ESC_CODE_ESC : ESC_CODE_FLAG, 1'b0);
      end else begin
        put_raw(b, last);
      end
    end
  endtask

  function automatic logic [15:0] pick_id();
    logic [15:0] id;
    case ($urandom_range(0, 3))
      0:       id = ID_HEARTBEAT;
      1:       id = ID_ALARM;
      2:       id = ID_PARAMETER;
      default: id = {pick_byte(), pick_byte()};
    endcase
    return id;
  endfunction

  // Wait cycles before the next transaction, with bursts of no waiting
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst = $urandom_range(8, 40);
    return $urandom_range(0, 5);
  endfunction

  function automatic void report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus: directed buffers first, then random frames
  // --------------------------------------------------------------------------
  initial begin
    int kind;
    int n;
    int next_drain;
    bit long_done;

    // heartbeat, good sum
    put_raw(FLAG_BYTE, 1'b0);
    put_raw(ID_HEARTBEAT[15:8], 1'b0);
    put_raw(ID_HEARTBEAT[7:0], 1'b0);
    put_raw(8'h02, 1'b0);
    put_raw(FLAG_BYTE, 1'b1);
    // alarm carrying an escaped 7d and an escaped 7e
    put_raw(FLAG_BYTE, 1'b0);
    put_raw(ID_ALARM[15:8], 1'b0);
    put_raw(ID_ALARM[7:0], 1'b0);
    put_raw(ESC_BYTE, 1'b0);
    put_raw(ESC_CODE_ESC, 1'b0);
    put_raw(ESC_BYTE, 1'b0);
    put_raw(ESC_CODE_FLAG, 1'b0);
    put_raw(8'hf2, 1'b0);
    put_raw(FLAG_BYTE, 1'b1);
    // one-byte buffer, then flags only: both too short
    put_raw(8'h00, 1'b1);
    put_raw(FLAG_BYTE, 1'b0);
    put_raw(FLAG_BYTE, 1'b1);
    // lone escape before ff (two results from one byte), escape as last byte
    put_raw(ESC_BYTE, 1'b0);
    put_raw(8'hff, 1'b0);
    put_raw(ESC_BYTE, 1'b1);
    // parameter id with a good sum but no opening flag
    put_raw(8'hff, 1'b0);
    put_raw(ID_PARAMETER[15:8], 1'b0);
    put_raw(ID_PARAMETER[7:0], 1'b0);
    put_raw(8'hf0, 1'b0);
    put_raw(FLAG_BYTE, 1'b1);
    put_drain();

    next_drain = DRAIN_SPACING;
    long_done  = 1'b0;
    while (raw_stream.size() < ITEM_TARGET) begin
      if (!long_done && raw_stream.size() > 400) begin
        // one frame around the length limit, where the count saturates
        build_frame(pick_id(), $urandom_range(MAX_LEN - 1, MAX_LEN + 6) - 5, 1'b1);
        put_frame();
        long_done = 1'b1;
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          build_frame(pick_id(), $urandom_range(0, 12), $urandom_range(0, 5) != 0);
          put_frame();
        end
        6: begin
          // good frame with one flag damaged
          build_frame(pick_id(), $urandom_range(0, 8), 1'b1);
          if ($urandom_range(0, 1)) frame_buf[0] = 8'($urandom_range(0, 255));
          else frame_buf[frame_buf.size() - 1] = 8'($urandom_range(0, 255));
          put_frame();
        end
        7: begin
          // under the minimum length
          frame_buf.delete();
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) frame_buf.push_back(pick_byte());
          put_frame();
        end
        8: begin
          // noise with buffer ends scattered through it
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++)
            put_raw(pick_byte(), (i == n - 1) || ($urandom_range(0, 5) == 0));
        end
        default: begin
          // escape-heavy buffer, ending on a flag or on a bare escape
          n = $urandom_range(2, 10);
          put_raw(FLAG_BYTE, 1'b0);
          for (int i = 0; i < n; i++)
            put_raw($urandom_range(0, 2) == 0 ? ESC_BYTE : pick_byte(), 1'b0);
          put_raw($urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE, 1'b1);
        end
      endcase
      if (raw_stream.size() >= next_drain) begin
        put_drain();
        next_drain += DRAIN_SPACING;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all bytes sent and every result back
    @(negedge clk);
    while (raw_stream.size() != 0 || data_valid || expected_decoded.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d raw bytes, checked %0d decoded bytes, longest frame %0d.",
             bytes_sent, results_checked, longest_frame);
    $display("Verdicts: %0d ok, %0d no flags, %0d bad sum, %0d too short.",
             verdict_tally[ST_OK], verdict_tally[ST_NO_FLAGS],
             verdict_tally[ST_BAD_SUM], verdict_tally[ST_TOO_SHORT]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: one raw byte per transaction, random gaps, drain pauses
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      data_valid    <= 1'b0;
      data_byte     <= '0;
      end_of_buffer <= 1'b0;
      send_gap = 0;
    end else begin
      if (data_valid && data_ready) begin
        unescape_byte(data_byte, end_of_buffer);
        bytes_sent++;
      end
      // free to present the next byte unless one is still waiting
      if (!data_valid || data_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          data_valid <= 1'b0;
        end else if (raw_stream.size() == 0) begin
          data_valid <= 1'b0;
        end else if (raw_stream[0].drain) begin
          data_valid <= 1'b0;
          if (expected_decoded.size() == 0) next_raw = raw_stream.pop_front();
        end else begin
          next_raw = raw_stream.pop_front();
          data_byte     <= next_raw.data;
          end_of_buffer <= next_raw.eob;
          data_valid    <= 1'b1;
          send_gap = draw_wait(send_burst);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result with the oldest expectation
  // --------------------------------------------------------------------------
  task automatic check_result();
    result_t got;
    result_t want;
    got.decoded_byte = decoded_byte;
    got.is_last      = is_last;
    got.status       = status_t'(status);
    got.msg_id       = msg_id;
    got.msg_class    = class_t'(msg_class);
    got.ack_needed   = ack_needed;
    got.frame_length = frame_length;
    if (expected_decoded.size() == 0) begin
      report_failure($sformatf("result with nothing expected: byte %h last %b",
                               decoded_byte, is_last));
      return;
    end
    want = expected_decoded.pop_front();
    if (want.is_last) begin
      verdict_tally[want.status]++;
      if (int'(want.frame_length) > longest_frame) longest_frame = int'(want.frame_length);
    end
    if (got.decoded_byte !== want.decoded_byte || got.is_last !== want.is_last ||
        got.status !== want.status || got.msg_id !== want.msg_id ||
        got.msg_class !== want.msg_class || got.ack_needed !== want.ack_needed ||
        got.frame_length !== want.frame_length)
      report_failure($sformatf({"mismatch on result %0d\n",
        "  exp byte %h last %b st %0d id %h cls %0d ack %b len %0d\n",
        "  got byte %h last %b st %0d id %h cls %0d ack %b len %0d"},
        results_checked,
        want.decoded_byte, want.is_last, want.status, want.msg_id,
        want.msg_class, want.ack_needed, want.frame_length,
        got.decoded_byte, got.is_last, got.status, got.msg_id,
        got.msg_class, got.ack_needed, got.frame_length));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (result_valid && result_ready) begin
        check_result();
        results_checked++;
        // now and then a long hold-off so the block backs up into its input
        if (results_checked % 1200 == 350) recv_stall = LONG_HOLD;
        else recv_stall = draw_wait(recv_burst);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (data_valid && data_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_decoded.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: frame_unescape_xor_check.f
rtl/fue_pkg.sv
rtl/fue_decode.sv
rtl/fue_out_queue.sv
rtl/frame_unescape_xor_check.sv
sim/tb_top.sv
